FILE: hdl/dao_pkg.sv
// Shared types, constants and helper functions of the delayed altitude observer.
`default_nettype none

package dao_pkg;

  localparam int DELAY_DEPTH = 16;
  localparam int IDX_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_SAMPLE_TIME = 3'd0;
  localparam logic [2:0] REG_BIAS_DECAY  = 3'd1;
  localparam logic [2:0] REG_GAIN_POS    = 3'd2;
  localparam logic [2:0] REG_GAIN_VEL    = 3'd3;
  localparam logic [2:0] REG_GAIN_BIAS   = 3'd4;
  localparam logic [2:0] REG_DELAY       = 3'd5;

  localparam logic signed [31:0] GRAVITY_Q16 = 32'sd642908;
  localparam logic signed [31:0] SIN_C3 = -32'sd178956868;
  localparam logic signed [31:0] SIN_C5 = 32'sd8947509;
  localparam logic signed [31:0] SIN_C7 = -32'sd212672;
  localparam logic signed [31:0] SIN_C9 = 32'sd2792;

  localparam logic signed [20:0] PI_Q     = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q = 21'sd411774;
  localparam logic signed [20:0] HALF_PI_Q = 21'sd102944;
  localparam int MOD_W = 20;
  localparam logic [MOD_W-1:0] MOD_Q = 20'd411774;
  // floor(2^32 / MOD_Q): quotient estimate is exact or one short
  localparam logic [31:0] RECIP_Q = 32'd10430;

  localparam logic [4:0] REDUCE_LAST = 5'd3;
  localparam logic [4:0] SINE_LAST   = 5'd6;
  localparam logic [4:0] TAIL_LAST   = 5'd13;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_REDUCE,
    S_SINE,
    S_TAIL,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_LDX,
    OP_XX,
    OP_P9,
    OP_P7,
    OP_P5,
    OP_P3,
    OP_PX,
    OP_CPSR,
    OP_CRCP,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_UTS,
    OP_POS,
    OP_VEL,
    OP_TW,
    OP_BIAS,
    OP_RING,
    OP_GP,
    OP_GV,
    OP_GB,
    OP_QP,
    OP_RP,
    OP_QR,
    OP_RR
  } op_t;

  typedef struct packed {
    logic       load_in;
    logic       init_load;
    logic       mod_start;
    logic       exec;
    logic       phase;
    op_t        op;
    logic [1:0] ang;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_init;
  } stat_t;

  typedef struct packed {
    logic signed [31:0] sample_time;
    logic signed [31:0] bias_decay;
    logic signed [31:0] gain_pos;
    logic signed [31:0] gain_vel;
    logic signed [31:0] gain_bias;
    logic [3:0]         delay;
  } cfg_t;

  function automatic op_t reduce_op(input logic [1:0] step);
    op_t o;
    case (step)
      2'd0:    o = OP_QP;
      2'd1:    o = OP_RP;
      2'd2:    o = OP_QR;
      default: o = OP_RR;
    endcase
    return o;
  endfunction

  function automatic op_t sine_op(input logic [2:0] step);
    op_t o;
    case (step)
      3'd0:    o = OP_LDX;
      3'd1:    o = OP_XX;
      3'd2:    o = OP_P9;
      3'd3:    o = OP_P7;
      3'd4:    o = OP_P5;
      3'd5:    o = OP_P3;
      3'd6:    o = OP_PX;
      default: o = OP_LDX;
    endcase
    return o;
  endfunction

  function automatic op_t tail_op(input logic [3:0] step);
    op_t o;
    case (step)
      4'd0:    o = OP_CPSR;
      4'd1:    o = OP_CRCP;
      4'd2:    o = OP_T1;
      4'd3:    o = OP_T2;
      4'd4:    o = OP_T3;
      4'd5:    o = OP_UTS;
      4'd6:    o = OP_POS;
      4'd7:    o = OP_VEL;
      4'd8:    o = OP_TW;
      4'd9:    o = OP_BIAS;
      4'd10:   o = OP_RING;
      4'd11:   o = OP_GP;
      4'd12:   o = OP_GV;
      4'd13:   o = OP_GB;
      default: o = OP_GB;
    endcase
    return o;
  endfunction

  // Bring a congruent angle back into [-pi, pi].
  function automatic logic signed [20:0] wrap_pi(input logic signed [20:0] r);
    logic signed [20:0] w;
    if (r > PI_Q) begin
      w = r - TWO_PI_Q;
    end else if (r < -PI_Q) begin
      w = r + TWO_PI_Q;
    end else begin
      w = r;
    end
    return w;
  endfunction

  // Mirror into [-pi/2, pi/2].
  function automatic logic signed [20:0] fold_half(input logic signed [20:0] r);
    logic signed [20:0] f;
    if (r > HALF_PI_Q) begin
      f = PI_Q - r;
    end else if (r < -HALF_PI_Q) begin
      f = -PI_Q - r;
    end else begin
      f = r;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/delayed_altitude_observer.sv
// Top level of the delayed altitude observer: register file, sequencer and datapath.
//
// Input channel (in_valid/in_ready) carries one item: opcode 1 loads position,
// velocity and bias and fills the delay ring; opcode 0 runs one filter update.
// Output channel (out_valid/out_ready) returns the three states after each item.
// An item is taken only while the block is idle; one item is in flight at a time.
// An update goes from transfer to result register through a start state,
// 46 steps of the one shared 33x33 multiplier (angle reduction by reciprocal
// multiply, four sine evaluations, rotation, prediction, correction) and the
// load of the result register. An initialize passes through the start and
// done states only. The result sits in an output register; a new item is
// accepted while it waits, and a finished item holds in the sequencer until
// out_ready frees that register. Reset (rst, synchronous) clears states, ring,
// index, registers and valid flags. The user writes configuration registers
// through the APB-style port only while idle; the block does not enforce it.
`default_nettype none

module delayed_altitude_observer import dao_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic signed [31:0] accel_x,
  input  wire logic signed [31:0] accel_y,
  input  wire logic signed [31:0] accel_z,
  input  wire logic signed [31:0] position,
  input  wire logic signed [31:0] roll,
  input  wire logic signed [31:0] pitch,
  input  wire logic signed [31:0] init_velocity,
  input  wire logic signed [31:0] init_bias,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      est_position,
  output logic signed [31:0]      est_velocity,
  output logic signed [31:0]      est_bias,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  dao_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dao_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dao_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .opcode        (opcode),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .position      (position),
    .roll          (roll),
    .pitch         (pitch),
    .init_velocity (init_velocity),
    .init_bias     (init_bias),
    .est_position  (est_position),
    .est_velocity  (est_velocity),
    .est_bias      (est_bias)
  );

endmodule

`default_nettype wire

FILE: hdl/dao_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module dao_regs import dao_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       regs;
  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr) begin
      case (index)
        REG_SAMPLE_TIME: regs.sample_time <= pwdata;
        REG_BIAS_DECAY:  regs.bias_decay  <= pwdata;
        REG_GAIN_POS:    regs.gain_pos    <= pwdata;
        REG_GAIN_VEL:    regs.gain_vel    <= pwdata;
        REG_GAIN_BIAS:   regs.gain_bias   <= pwdata;
        REG_DELAY:       regs.delay       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_SAMPLE_TIME: prdata = regs.sample_time;
      REG_BIAS_DECAY:  prdata = regs.bias_decay;
      REG_GAIN_POS:    prdata = regs.gain_pos;
      REG_GAIN_VEL:    prdata = regs.gain_vel;
      REG_GAIN_BIAS:   prdata = regs.gain_bias;
      REG_DELAY:       prdata = {28'd0, regs.delay};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/dao_ctrl.sv
// Sequencer: handshakes, angle reduction timing and the multiply schedule.
`default_nettype none

module dao_ctrl import dao_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  stat_t     stat,
  output cmd_t      cmd
);

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] ang, ang_next;
  logic       phase, phase_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ang       <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ang       <= ang_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ang_next   = ang;
    phase_next = phase;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.phase  = phase;
    cmd.ang    = ang;
    if (state == S_TAIL) begin
      cmd.op = tail_op(cnt[3:0]);
    end else if (state == S_REDUCE) begin
      cmd.op = reduce_op(cnt[1:0]);
    end else begin
      cmd.op = sine_op(cnt[2:0]);
    end

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (stat.is_init) begin
          cmd.init_load = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.mod_start = 1'b1;
          cnt_next      = '0;
          phase_next    = 1'b0;
          state_next    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.exec   = 1'b1;
        phase_next = ~phase;
        if (phase) begin
          cnt_next = cnt + 5'd1;
          if (cnt == REDUCE_LAST) begin
            cnt_next   = '0;
            ang_next   = '0;
            state_next = S_SINE;
          end
        end
      end
      S_SINE: begin
        cmd.exec   = 1'b1;
        phase_next = ~phase;
        if (phase) begin
          cnt_next = cnt + 5'd1;
          if (cnt == SINE_LAST) begin
            cnt_next = '0;
            ang_next = ang + 2'd1;
            if (ang == 2'd3) begin
              state_next = S_TAIL;
            end
          end
        end
      end
      S_TAIL: begin
        cmd.exec   = 1'b1;
        phase_next = ~phase;
        if (phase) begin
          cnt_next = cnt + 5'd1;
          if (cnt == TAIL_LAST) begin
            cnt_next   = '0;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_START))
    else $error("accepted item did not start");

  a_phase_pairs: assert property (@(posedge clk) disable iff (rst)
    (state == S_SINE && !phase) |=> (state == S_SINE && phase))
    else $error("multiply step lost its write-back phase");

  a_sine_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SINE) |-> (cnt <= SINE_LAST))
    else $error("sine step out of range");
`endif

endmodule

`default_nettype wire

FILE: hdl/dao_dp.sv
// Datapath: input and result registers, angle reduction, shared multiplier, states and ring.
`default_nettype none

module dao_dp import dao_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  cfg_t                    cfg,
  input  wire logic               opcode,
  input  wire logic signed [31:0] accel_x,
  input  wire logic signed [31:0] accel_y,
  input  wire logic signed [31:0] accel_z,
  input  wire logic signed [31:0] position,
  input  wire logic signed [31:0] roll,
  input  wire logic signed [31:0] pitch,
  input  wire logic signed [31:0] init_velocity,
  input  wire logic signed [31:0] init_bias,
  output logic signed [31:0]      est_position,
  output logic signed [31:0]      est_velocity,
  output logic signed [31:0]      est_bias
);

  // captured item
  logic               op_r;
  logic signed [31:0] ax, ay, az, meas, roll_r, pitch_r, iv, ib;

  // angle reduction
  logic [31:0]        mag_p, mag_r, mag_sel, diff, diff_sub;
  logic [12:0]        quo;
  logic [MOD_W-1:0]   rem_p, rem_r, rem_fix;
  logic               neg_p, neg_r;
  logic signed [20:0] srem_p, srem_r, base, arg, red;
  logic signed [31:0] xw;

  // multiplier and working registers
  logic signed [32:0] ma, mb;
  logic signed [65:0] p;
  logic signed [31:0] sx, pa, nsp, cp, sr, cr, cpsr, crcp, u, inner, tw, e;
  logic signed [32:0] sx2;
  logic signed [31:0] s_val, azb;

  // filter state
  logic signed [31:0] pos, vel, bias;
  logic signed [31:0] ring [DELAY_DEPTH];
  logic [IDX_W-1:0]   idx, dmax, wi, idx_adv;
  logic [IDX_W:0]     nxt;

  assign stat.is_init = op_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= opcode;
      ax      <= accel_x;
      ay      <= accel_y;
      az      <= accel_z;
      meas    <= position;
      roll_r  <= roll;
      pitch_r <= pitch;
      iv      <= init_velocity;
      ib      <= init_bias;
    end
  end

  // reduce the magnitude of each angle modulo 2*pi, sign restored afterwards
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      mag_p <= pitch_r[31] ? -pitch_r : pitch_r;
      mag_r <= roll_r[31] ? -roll_r : roll_r;
      neg_p <= pitch_r[31];
      neg_r <= roll_r[31];
    end
  end

  // remainder from the quotient estimate, with one corrective subtract
  always_comb begin
    mag_sel  = (cmd.op == OP_QR || cmd.op == OP_RR) ? mag_r : mag_p;
    diff     = mag_sel - p[31:0];
    diff_sub = diff - {12'd0, MOD_Q};
    if (diff >= {12'd0, MOD_Q}) begin
      rem_fix = diff_sub[MOD_W-1:0];
    end else begin
      rem_fix = diff[MOD_W-1:0];
    end
  end

  assign srem_p = neg_p ? -$signed({1'b0, rem_p}) : $signed({1'b0, rem_p});
  assign srem_r = neg_r ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});

  // angle for this sine pass: pitch or roll, sine or cosine
  always_comb begin
    base = wrap_pi(cmd.ang[1] ? srem_r : srem_p);
    arg  = cmd.ang[0] ? wrap_pi(base + HALF_PI_Q) : base;
    red  = fold_half(arg);
    xw   = {{11{red[20]}}, red};
  end

  assign azb   = az - bias;
  assign s_val = sx + p[61:30];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_QP:   begin ma = {1'b0, mag_p};      mb = {1'b0, RECIP_Q};    end
      OP_QR:   begin ma = {1'b0, mag_r};      mb = {1'b0, RECIP_Q};    end
      OP_RP:   begin ma = {20'd0, quo};       mb = {13'd0, MOD_Q};     end
      OP_RR:   begin ma = {20'd0, quo};       mb = {13'd0, MOD_Q};     end
      OP_XX:   begin ma = {sx[31], sx};       mb = {sx[31], sx};       end
      OP_P9:   begin ma = sx2;                mb = {SIN_C9[31], SIN_C9}; end
      OP_P7:   begin ma = sx2;                mb = {pa[31], pa};       end
      OP_P5:   begin ma = sx2;                mb = {pa[31], pa};       end
      OP_P3:   begin ma = sx2;                mb = {pa[31], pa};       end
      OP_PX:   begin ma = {sx[31], sx};       mb = {pa[31], pa};       end
      OP_CPSR: begin ma = {cp[31], cp};       mb = {sr[31], sr};       end
      OP_CRCP: begin ma = {cr[31], cr};       mb = {cp[31], cp};       end
      OP_T1:   begin ma = {nsp[31], nsp};     mb = {ax[31], ax};       end
      OP_T2:   begin ma = {cpsr[31], cpsr};   mb = {ay[31], ay};       end
      OP_T3:   begin ma = {crcp[31], crcp};   mb = {azb[31], azb};     end
      OP_UTS:  begin ma = {u[31], u};         mb = {cfg.sample_time[31], cfg.sample_time}; end
      OP_POS:  begin ma = {inner[31], inner}; mb = {cfg.sample_time[31], cfg.sample_time}; end
      OP_VEL:  begin ma = {u[31], u};         mb = {cfg.sample_time[31], cfg.sample_time}; end
      OP_TW:   begin ma = {cfg.bias_decay[31], cfg.bias_decay};
                     mb = {cfg.sample_time[31], cfg.sample_time}; end
      OP_BIAS: begin ma = {tw[31], tw};       mb = {bias[31], bias};   end
      OP_GP:   begin ma = {cfg.gain_pos[31], cfg.gain_pos};   mb = {e[31], e}; end
      OP_GV:   begin ma = {cfg.gain_vel[31], cfg.gain_vel};   mb = {e[31], e}; end
      OP_GB:   begin ma = {cfg.gain_bias[31], cfg.gain_bias}; mb = {e[31], e}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  // ring index arithmetic
  always_comb begin
    if ({28'd0, cfg.delay} < 32'(DELAY_DEPTH)) begin
      dmax = IDX_W'(cfg.delay);
    end else begin
      dmax = IDX_W'(DELAY_DEPTH - 1);
    end
    if ({1'b0, idx} >= (IDX_W+1)'(DELAY_DEPTH)) begin
      wi = '0;
    end else begin
      wi = idx;
    end
    nxt = {1'b0, wi} + (IDX_W+1)'(1);
    if (nxt > {1'b0, dmax}) begin
      idx_adv = '0;
    end else begin
      idx_adv = nxt[IDX_W-1:0];
    end
  end

  // working registers written back from the product
  always_ff @(posedge clk) begin
    if (cmd.exec && !cmd.phase && cmd.op == OP_LDX) begin
      sx <= xw <<< 14;
    end
    if (cmd.exec && cmd.phase) begin
      case (cmd.op)
        OP_QP:   quo <= p[44:32];
        OP_QR:   quo <= p[44:32];
        OP_RP:   rem_p <= rem_fix;
        OP_RR:   rem_r <= rem_fix;
        OP_XX:   sx2 <= p[62:30];
        OP_P9:   pa <= SIN_C7 + p[61:30];
        OP_P7:   pa <= SIN_C5 + p[61:30];
        OP_P5:   pa <= SIN_C3 + p[61:30];
        OP_P3:   pa <= p[61:30];
        OP_PX: begin
          case (cmd.ang)
            2'd0:    nsp <= -s_val;
            2'd1:    cp  <= s_val;
            2'd2:    sr  <= s_val;
            default: cr  <= s_val;
          endcase
        end
        OP_CPSR: cpsr  <= p[61:30];
        OP_CRCP: crcp  <= p[61:30];
        OP_T1:   u     <= p[61:30];
        OP_T2:   u     <= u + p[61:30];
        OP_T3:   u     <= u + p[61:30] - GRAVITY_Q16;
        OP_UTS:  inner <= vel + p[62:31];
        OP_TW:   tw    <= p[61:30];
        OP_RING: e     <= meas - ring[idx];
        default: ;
      endcase
    end
  end

  // filter state and delay ring
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      vel  <= '0;
      bias <= '0;
      idx  <= '0;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else if (cmd.init_load) begin
      pos  <= meas;
      vel  <= iv;
      bias <= ib;
      idx  <= '0;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        if (IDX_W'(i) <= dmax) begin
          ring[i] <= meas;
        end
      end
    end else if (cmd.exec && !cmd.phase && cmd.op == OP_RING) begin
      ring[wi] <= pos;
      idx      <= idx_adv;
    end else if (cmd.exec && cmd.phase) begin
      case (cmd.op)
        OP_POS:  pos  <= pos + p[61:30];
        OP_VEL:  vel  <= vel + p[61:30];
        OP_BIAS: bias <= bias - p[47:16];
        OP_GP:   pos  <= pos + p[61:30];
        OP_GV:   vel  <= vel + p[61:30];
        OP_GB:   bias <= bias + p[61:30];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      est_position <= pos;
      est_velocity <= vel;
      est_bias     <= bias;
    end
  end

endmodule

`default_nettype wire
